// ===== rtl/pmstk_pkg.sv =====
// Shared constants, codes and control types for the position mark stack.
package pmstk_pkg;

	// Sizing of the stack and of the stored fields.
	localparam int STACK_DEPTH   = 16;
	localparam int ID_BITS       = 16;
	localparam int POSITION_BITS = 32;

	// Derived widths.
	localparam int IDX_W    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CNT_W    = $clog2(STACK_DEPTH + 1);
	localparam int CID_W    = ID_BITS + 1;
	localparam int ENTRY_W  = ID_BITS + POSITION_BITS;
	localparam int CMD_W    = 2;
	localparam int STATUS_W = 2;

	// Request command codes.
	typedef enum logic [CMD_W-1:0] {
		OP_PUSH       = 2'd0,
		OP_RESTORE    = 2'd1,
		OP_POP_UNTIL  = 2'd2,
		OP_DROP_ALL   = 2'd3
	} pmstk_op_t;

	// Result status codes.
	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2
	} pmstk_status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_req;   // capture the incoming request
		logic exec;       // first step of the request
		logic rd_en;      // read the mark at the search index
		logic take_hit;   // the mark just read is the one searched for
		logic take_miss;  // search ran out of marks
		logic idx_dec;    // move the search index one mark down
		logic load_out;   // move the result into the output register
	} pmstk_ctl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic need_scan;  // request needs a read of the stack
		logic hit;        // the mark just read matches
		logic idx_zero;   // search index is at the oldest mark
	} pmstk_sts_t;

endpackage

// ===== rtl/pmstk_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module pmstk_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Storage array and registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/pmstk_ctrl.sv =====
// Sequencing controller for the position mark stack.
module pmstk_ctrl
	import pmstk_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  pmstk_sts_t sts,
	output pmstk_ctl_t ctl
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_READ,
		S_CHECK,
		S_DONE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	// The output register can take a result when empty or being emptied.
	assign out_free = !out_valid_q || out_ready;

	// Command decode from the current state.
	always_comb begin
		ctl           = '0;
		ctl.load_req  = (state_q == S_IDLE) && in_valid;
		ctl.exec      = (state_q == S_EXEC);
		ctl.rd_en     = (state_q == S_READ);
		ctl.take_hit  = (state_q == S_CHECK) && sts.hit;
		ctl.take_miss = (state_q == S_CHECK) && !sts.hit && sts.idx_zero;
		ctl.idx_dec   = (state_q == S_CHECK) && !sts.hit && !sts.idx_zero;
		ctl.load_out  = (state_q == S_DONE) && out_free;
	end

	// State register and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= sts.need_scan ? S_READ : S_DONE;
				end
				S_READ: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (sts.hit || sts.idx_zero) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_READ;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (ctl.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

endmodule

// ===== rtl/pmstk_dp.sv =====
// Datapath of the position mark stack: request registers, counters, mark RAM and results.
module pmstk_dp
	import pmstk_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [CMD_W-1:0]         command,
	input  logic [POSITION_BITS-1:0] read_position,
	input  logic [CID_W-1:0]         context_id,
	input  pmstk_ctl_t               ctl,
	output pmstk_sts_t               sts,
	output logic [STATUS_W-1:0]      status,
	output logic [POSITION_BITS-1:0] position,
	output logic [ID_BITS-1:0]       assigned_id,
	output logic [CNT_W-1:0]         mark_count
);

	pmstk_op_t                req_op_q;
	logic [POSITION_BITS-1:0] req_pos_q;
	logic [CID_W-1:0]         req_cid_q;
	logic [CNT_W-1:0]         count_q;
	logic [ID_BITS-1:0]       id_ctr_q;
	logic [IDX_W-1:0]         idx_q;
	pmstk_status_t            res_status_q;
	logic [POSITION_BITS-1:0] res_pos_q;
	logic [ID_BITS-1:0]       res_id_q;
	pmstk_status_t            out_status_q;
	logic [POSITION_BITS-1:0] out_pos_q;
	logic [ID_BITS-1:0]       out_id_q;
	logic [CNT_W-1:0]         out_count_q;

	logic               full;
	logic               newest;
	logic               negative;
	logic               ram_wr_en;
	logic [ENTRY_W-1:0] ram_rd_data;
	logic [ID_BITS-1:0] rd_id;
	logic [POSITION_BITS-1:0] rd_pos;

	// Request decode.
	assign full     = (count_q == CNT_W'(STACK_DEPTH));
	assign newest   = (req_cid_q == {CID_W{1'b1}});
	assign negative = req_cid_q[CID_W-1];
	assign ram_wr_en = ctl.exec && (req_op_q == OP_PUSH) && !full;

	// Each entry holds the id above the position.
	assign rd_id  = ram_rd_data[ENTRY_W-1 -: ID_BITS];
	assign rd_pos = ram_rd_data[POSITION_BITS-1:0];

	pmstk_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(STACK_DEPTH)
	) u_mark_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (count_q[IDX_W-1:0]),
		.wr_data ({id_ctr_q, req_pos_q}),
		.rd_en   (ctl.rd_en),
		.rd_addr (idx_q),
		.rd_data (ram_rd_data)
	);

	// Status back to the controller.
	always_comb begin
		sts.need_scan = (count_q != '0) && (newest || !negative)
			&& ((req_op_q == OP_RESTORE) || (req_op_q == OP_POP_UNTIL));
		sts.hit       = newest || (rd_id == req_cid_q[ID_BITS-1:0]);
		sts.idx_zero  = (idx_q == '0);
	end

	// Stack fill count and id counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			id_ctr_q <= '0;
		end else begin
			if (ctl.exec) begin
				case (req_op_q)
					OP_PUSH: begin
						if (!full) begin
							count_q  <= count_q + CNT_W'(1);
							id_ctr_q <= id_ctr_q + ID_BITS'(1);
						end
					end
					OP_DROP_ALL: begin
						count_q  <= '0;
						id_ctr_q <= '0;
					end
					default: begin
						// A pop-until that cannot search empties the stack.
						if (!sts.need_scan && (req_op_q == OP_POP_UNTIL)) begin
							count_q <= '0;
						end
					end
				endcase
			end else if (ctl.take_hit && (req_op_q == OP_POP_UNTIL)) begin
				count_q <= CNT_W'(idx_q) + CNT_W'(1);
			end else if (ctl.take_miss && (req_op_q == OP_POP_UNTIL)) begin
				count_q <= '0;
			end
		end
	end

	// Request capture, search index and result staging.
	always_ff @(posedge clk) begin
		if (ctl.load_req) begin
			req_op_q  <= pmstk_op_t'(command);
			req_pos_q <= read_position;
			req_cid_q <= context_id;
		end

		if (ctl.exec) begin
			res_status_q <= ST_OK;
			res_pos_q    <= '0;
			res_id_q     <= '0;
			idx_q        <= IDX_W'(count_q - CNT_W'(1));
			case (req_op_q)
				OP_PUSH: begin
					if (full) begin
						res_status_q <= ST_FULL;
					end else begin
						res_id_q <= id_ctr_q;
					end
				end
				OP_RESTORE, OP_POP_UNTIL: begin
					if (!sts.need_scan) begin
						res_status_q <= ST_NOT_FOUND;
					end
				end
				default: begin
				end
			endcase
		end else if (ctl.take_hit) begin
			if (req_op_q == OP_RESTORE) begin
				res_pos_q <= rd_pos;
			end
		end else if (ctl.take_miss) begin
			res_status_q <= ST_NOT_FOUND;
		end else if (ctl.idx_dec) begin
			idx_q <= idx_q - IDX_W'(1);
		end

		if (ctl.load_out) begin
			out_status_q <= res_status_q;
			out_pos_q    <= res_pos_q;
			out_id_q     <= res_id_q;
			out_count_q  <= count_q;
		end
	end

	assign status      = out_status_q;
	assign position    = out_pos_q;
	assign assigned_id = out_id_q;
	assign mark_count  = out_count_q;

endmodule

// ===== rtl/position_mark_stack_top.sv =====
// Top level of the position mark stack: controller, datapath and checks.
//
//   Channel   Direction  Handshake            Payload
//   request   in         in_valid / in_ready  command, read_position, context_id
//   result    out        out_valid/out_ready  status, position, assigned_id, mark_count
//
// Push and drop-all pass from acceptance through the execute state to the
// done state, which loads the output register; the next request is taken once
// the controller is back in idle. Restore and pop-until walk the mark RAM from
// the newest mark down, one read and one compare per mark, visiting at most
// the number of marks held, and none on an empty stack or a negative id other
// than -1. Reset is asynchronous and clears the mark count and the id counter;
// no clearing pass runs. While a result waits on out_ready, one more request
// can be accepted and worked on; it then waits until the output register frees.
module position_mark_stack_top
	import pmstk_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [CMD_W-1:0]         command,
	input  logic [POSITION_BITS-1:0] read_position,
	input  logic [CID_W-1:0]         context_id,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [STATUS_W-1:0]      status,
	output logic [POSITION_BITS-1:0] position,
	output logic [ID_BITS-1:0]       assigned_id,
	output logic [CNT_W-1:0]         mark_count
);

	pmstk_ctl_t ctl;
	pmstk_sts_t sts;

	pmstk_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	pmstk_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.command       (command),
		.read_position (read_position),
		.context_id    (context_id),
		.ctl           (ctl),
		.sts           (sts),
		.status        (status),
		.position      (position),
		.assigned_id   (assigned_id),
		.mark_count    (mark_count)
	);

	// The stack never reports more marks than it can hold.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (mark_count <= CNT_W'(STACK_DEPTH)))
		else $error("mark count above stack depth");

	// A refused push gives no id and no position.
	a_full_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == ST_FULL)) |-> ((assigned_id == '0) && (position == '0)))
		else $error("full status with nonzero payload");

	// A failed search gives position zero.
	a_miss_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == ST_NOT_FOUND)) |-> (position == '0))
		else $error("not-found status with nonzero position");

	// An accepted request keeps the input closed while it is worked on.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("request accepted while another is in progress");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the position mark stack: predictor, drivers and checks.
`timescale 1ns / 100ps

module testbench
	import pmstk_pkg::*;
;

	// Run length and timing limits.
	localparam int RANDOM_REQUESTS = 650;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int DRAIN_CYCLES    = 3 + 2 * STACK_DEPTH + 10;
	localparam int FINAL_ROUNDS    = 4;

	// Context id that selects the newest mark.
	localparam logic [CID_W-1:0] NEWEST_ID = '1;

	// Mirror of the mark stack that predicts every result, plus the result check.
	class mark_result_board;
		typedef struct {
			pmstk_status_t            status;
			logic [POSITION_BITS-1:0] position;
			logic [ID_BITS-1:0]       assigned_id;
			logic [CNT_W-1:0]         mark_count;
		} mark_result_t;

		logic [ID_BITS-1:0]       saved_ids[STACK_DEPTH];
		logic [POSITION_BITS-1:0] saved_positions[STACK_DEPTH];
		int                       marks_held;
		logic [ID_BITS-1:0]       next_id;
		mark_result_t             expected_results[$];
		int                       mismatches;

		function new();
			marks_held = 0;
			next_id    = '0;
			mismatches = 0;
		endfunction

		// Newest slot holding the id; -1 selects the top mark, other negatives match nothing.
		function int find_slot(logic [CID_W-1:0] cid);
			if (marks_held == 0)
				return -1;
			if (cid == NEWEST_ID)
				return marks_held - 1;
			if (cid[CID_W-1])
				return -1;
			for (int i = marks_held - 1; i >= 0; i--) begin
				if (saved_ids[i] == cid[ID_BITS-1:0])
					return i;
			end
			return -1;
		endfunction

		// Apply one accepted request to the mirror and queue the result it must give.
		function void note_request(pmstk_op_t op, logic [POSITION_BITS-1:0] pos,
				logic [CID_W-1:0] cid);
			mark_result_t res;
			int           slot;
			res.status      = ST_OK;
			res.position    = '0;
			res.assigned_id = '0;
			case (op)
			OP_PUSH: begin
				if (marks_held >= STACK_DEPTH) begin
					res.status = ST_FULL;
				end else begin
					saved_ids[marks_held]       = next_id;
					saved_positions[marks_held] = pos;
					marks_held++;
					res.assigned_id = next_id;
					next_id++;
				end
			end
			OP_RESTORE: begin
				slot = find_slot(cid);
				if (slot < 0)
					res.status = ST_NOT_FOUND;
				else
					res.position = saved_positions[slot];
			end
			OP_POP_UNTIL: begin
				slot = find_slot(cid);
				if (slot < 0) begin
					marks_held = 0;
					res.status = ST_NOT_FOUND;
				end else begin
					marks_held = slot + 1;
				end
			end
			default: begin
				marks_held = 0;
				next_id    = '0;
			end
			endcase
			res.mark_count = CNT_W'(marks_held);
			expected_results.push_back(res);
		endfunction

		task report_mismatch(string what);
			mismatches++;
			if (mismatches <= 100)
				$display("%0t: mismatch: %s", $time, what);
		endtask

		// Compare one accepted result with the oldest outstanding prediction.
		task check_result(logic [STATUS_W-1:0] st, logic [POSITION_BITS-1:0] pos,
				logic [ID_BITS-1:0] aid, logic [CNT_W-1:0] cnt);
			mark_result_t want;
			if (expected_results.size() == 0) begin
				report_mismatch("result with no request outstanding");
				return;
			end
			want = expected_results.pop_front();
			if (st !== want.status)
				report_mismatch($sformatf("status %0d, expected %0d", st, want.status));
			if (pos !== want.position)
				report_mismatch($sformatf("position %h, expected %h", pos, want.position));
			if (aid !== want.assigned_id)
				report_mismatch($sformatf("assigned_id %0d, expected %0d", aid,
					want.assigned_id));
			if (cnt !== want.mark_count)
				report_mismatch($sformatf("mark_count %0d, expected %0d", cnt,
					want.mark_count));
		endtask
	endclass

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic [CMD_W-1:0]         command = '0;
	logic [POSITION_BITS-1:0] read_position = '0;
	logic [CID_W-1:0]         context_id = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic [STATUS_W-1:0]      status;
	logic [POSITION_BITS-1:0] position;
	logic [ID_BITS-1:0]       assigned_id;
	logic [CNT_W-1:0]         mark_count;

	mark_result_board board = new();

	// Idle control shared by the two sides.
	bit idle_on = 1'b1;
	bit sender_steady = 1'b0;
	int hold_off_requests = 0;
	int quiet_cycles = 0;

	position_mark_stack_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.command       (command),
		.read_position (read_position),
		.context_id    (context_id),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.position      (position),
		.assigned_id   (assigned_id),
		.mark_count    (mark_count)
	);

	// 12 ns clock.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Offer one request, with an optional idle burst first, and wait until it is taken.
	task automatic send_request(pmstk_op_t op, logic [POSITION_BITS-1:0] pos,
			logic [CID_W-1:0] cid);
		if (idle_on && !sender_steady && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		in_valid      <= 1'b1;
		command       <= op;
		read_position <= pos;
		context_id    <= cid;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	// Mostly ids of marks on the stack, sometimes the newest-mark code or anything at all.
	function automatic logic [CID_W-1:0] pick_mark_id();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll < 6 && board.marks_held > 0)
			return {1'b0, board.saved_ids[$urandom_range(0, board.marks_held - 1)]};
		if (roll < 8)
			return NEWEST_ID;
		return CID_W'($urandom_range(0, (1 << CID_W) - 1));
	endfunction

	// Result side: random stall bursts, quiet stretches, and one long hold-off on request.
	initial begin : result_sink
		int hold_left;
		int mode_left;
		int stall_odds;
		int hold_offs_done;
		hold_left      = 0;
		mode_left      = 0;
		stall_odds     = 0;
		hold_offs_done = 0;
		forever begin
			@(posedge clk);
			if (mode_left == 0) begin
				mode_left  = $urandom_range(20, 120);
				stall_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 8);
			end
			mode_left--;
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (hold_offs_done < hold_off_requests) begin
				hold_offs_done++;
				hold_left = HOLD_OFF_CYCLES - 1;
				out_ready <= 1'b0;
			end else if (idle_on && stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
				hold_left = $urandom_range(1, 9) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Request and result monitors, and the watchdog on handshake progress.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				board.note_request(pmstk_op_t'(command), read_position, context_id);
			if (out_valid && out_ready)
				board.check_result(status, position, assigned_id, mark_count);
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("testbench NOT OK");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// Stimulus: directed cases, random traffic, then full-stack rounds without idling.
	initial begin : stimulus
		int k;
		int roll;
		int round;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty stack, field extremes, missing and negative ids.
		send_request(OP_RESTORE, '0, NEWEST_ID);
		send_request(OP_POP_UNTIL, '1, NEWEST_ID);
		send_request(OP_PUSH, '0, '0);
		send_request(OP_PUSH, '1, '1);
		send_request(OP_PUSH, 32'h8000_0001, 17'h0_5a5a);
		send_request(OP_RESTORE, '0, NEWEST_ID);
		send_request(OP_RESTORE, '1, 17'd0);
		send_request(OP_RESTORE, '0, 17'd1);
		send_request(OP_RESTORE, '0, 17'h0_ffff);
		send_request(OP_RESTORE, '0, 17'h1_fffe);
		send_request(OP_RESTORE, '0, 17'h1_0000);
		send_request(OP_POP_UNTIL, '0, NEWEST_ID);
		send_request(OP_POP_UNTIL, '0, 17'd1);
		send_request(OP_POP_UNTIL, '0, 17'h1_fffb);
		send_request(OP_PUSH, 32'h0000_ffff, '0);
		send_request(OP_PUSH, 32'hffff_0000, '0);
		send_request(OP_POP_UNTIL, '0, 17'd12345);
		send_request(OP_DROP_ALL, '1, '1);
		send_request(OP_PUSH, 32'h1234_5678, '0);
		send_request(OP_PUSH, 32'h7fff_ffff, '0);
		send_request(OP_DROP_ALL, '0, '0);
		send_request(OP_PUSH, 32'hdead_beef, '0);

		// Random traffic: push runs, searches for held ids, drop-alls and noise.
		k = 0;
		while (k < RANDOM_REQUESTS) begin
			if (k % 100 == 0)
				sender_steady = ($urandom_range(0, 2) == 0);
			if (k >= 300 && hold_off_requests == 0)
				hold_off_requests++;
			roll = $urandom_range(0, 99);
			if (roll < 35) begin
				send_request(OP_PUSH, $urandom(), CID_W'($urandom()));
				k++;
			end else if (roll < 43) begin
				repeat ($urandom_range(4, 18)) begin
					send_request(OP_PUSH, $urandom(), CID_W'($urandom()));
					k++;
				end
			end else if (roll < 68) begin
				send_request(OP_RESTORE, $urandom(), pick_mark_id());
				k++;
			end else if (roll < 90) begin
				send_request(OP_POP_UNTIL, $urandom(), pick_mark_id());
				k++;
			end else if (roll < 94) begin
				send_request(OP_DROP_ALL, $urandom(), CID_W'($urandom()));
				k++;
			end else begin
				send_request(pmstk_op_t'($urandom_range(0, 3)), $urandom(),
					CID_W'($urandom_range(0, (1 << CID_W) - 1)));
				k++;
			end
		end

		// No idling from here on. A base mark with id 0 stays at the bottom while
		// rounds of pushes fill the stack and pop back down to it.
		idle_on = 1'b0;
		send_request(OP_DROP_ALL, '0, '0);
		send_request(OP_PUSH, $urandom(), '0);
		for (round = 0; round < FINAL_ROUNDS; round++) begin
			repeat (STACK_DEPTH - 1)
				send_request(OP_PUSH, $urandom(), CID_W'($urandom()));
			// A push onto the full stack must be refused.
			send_request(OP_PUSH, $urandom(), '0);
			send_request(OP_POP_UNTIL, $urandom(), '0);
		end

		// Searches around the base mark left at the bottom.
		send_request(OP_PUSH, $urandom(), '0);
		send_request(OP_RESTORE, '0, 17'd0);
		send_request(OP_RESTORE, '0, NEWEST_ID);
		send_request(OP_POP_UNTIL, '0, 17'd0);
		send_request(OP_PUSH, $urandom(), '0);
		send_request(OP_POP_UNTIL, '0, 17'd0);
		send_request(OP_RESTORE, '0, 17'd0);
		send_request(OP_DROP_ALL, '0, '0);
		in_valid <= 1'b0;

		// Let every outstanding result arrive, then watch for stray ones.
		while (board.expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.mismatches == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
